/* src/monitor_link_pec_framer_core_assert.svh */
// Assertion macros shared by the framer modules.
`ifndef MONITOR_LINK_PEC_FRAMER_CORE_ASSERT_SVH
`define MONITOR_LINK_PEC_FRAMER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define MLPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define MLPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MLPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MLPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/mlpf_pkg.sv */
// Types, constants and CRC step functions of the link PEC framer.
package mlpf_pkg;

    localparam int COMMAND_BYTES_DEF = 2;
    localparam int DATA_BYTES_DEF    = 6;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [14:0] CRC_SEED = 15'd16;
    localparam logic [14:0] POLY15   = 15'h4599;
    localparam logic [9:0]  POLY10   = 10'h08F;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_PEC    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef enum logic [1:0] {
        MODE_CMD  = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2,
        MODE_IDLE = 2'd3
    } frame_mode_t;

    // Work handed from the front end to the back end.
    typedef enum logic [1:0] {
        JOB_BYTE    = 2'd0,
        JOB_CMD_PEC = 2'd1,
        JOB_TX_PEC  = 2'd2,
        JOB_STATUS  = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t   job;
        logic [7:0]  data;
        logic [14:0] crc;
        logic [5:0]  counter;
        logic [9:0]  rx_pec;
    } job_t;

    // One byte of CRC-15, MSB first.
    function automatic logic [14:0] crc15_byte(input logic [14:0] crc, input logic [7:0] b);
        logic [14:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[14] ^ b[i];
            c  = {c[13:0], 1'b0};
            if (fb) begin
                c = c ^ POLY15;
            end
        end
        return c;
    endfunction

    // One byte of CRC-10, MSB first.
    function automatic logic [9:0] crc10_byte(input logic [9:0] crc, input logic [7:0] b);
        logic [9:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[9] ^ b[i];
            c  = {c[8:0], 1'b0};
            if (fb) begin
                c = c ^ POLY10;
            end
        end
        return c;
    endfunction

    // Folds the six counter bits into the CRC-10 with six more bit steps.
    function automatic logic [9:0] pec10_finish(input logic [9:0] crc, input logic [5:0] cnt);
        logic [9:0] c;
        c = crc ^ {cnt, 4'b0000};
        for (int i = 0; i < 6; i++) begin
            if (c[9]) begin
                c = {c[8:0], 1'b0} ^ POLY10;
            end else begin
                c = {c[8:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* src/mlpf_front.sv */
// Front end: takes input beats, tracks the frame and runs the byte-wide CRC.
module mlpf_front
    import mlpf_pkg::*;
#(
    parameter int COMMAND_BYTES = COMMAND_BYTES_DEF,
    parameter int DATA_BYTES    = DATA_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       q_full,
    input  logic [1:0] op,
    input  logic [7:0] data_byte,
    input  logic       first,
    output logic       full,
    output logic       job_wr,
    output job_t       job
);

    localparam int POS_W = $clog2(DATA_BYTES + COMMAND_BYTES + 2);

    frame_mode_t  frame_mode_reg, frame_mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [14:0]  crc_reg, crc_next;
    logic [5:0]   saved_counter_reg, saved_counter_next;
    logic [1:0]   saved_pec_high_reg, saved_pec_high_next;

    frame_mode_t      mode_cur;
    logic [POS_W-1:0] pos_cur;
    logic [POS_W-1:0] pos_inc;
    logic [14:0]      crc_cur;
    logic [14:0]      crc15_new;
    logic [9:0]       crc10_new;
    logic             accept;
    logic             has_job;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign job_wr = accept && has_job;

    // A first beat restarts the frame before the byte is processed.
    always_comb
    begin
        mode_cur  = first ? frame_mode_t'(op) : frame_mode_reg;
        pos_cur   = first ? '0 : pos_reg;
        crc_cur   = first ? CRC_SEED : crc_reg;
        pos_inc   = pos_cur + 1'b1;
        crc15_new = crc15_byte(crc_cur, data_byte);
        crc10_new = crc10_byte(crc_cur[9:0], data_byte);
    end

    // Classify the beat and work out the next frame state.
    always_comb
    begin
        frame_mode_next     = mode_cur;
        pos_next            = pos_cur;
        crc_next            = crc_cur;
        saved_counter_next  = saved_counter_reg;
        saved_pec_high_next = saved_pec_high_reg;
        has_job             = 1'b0;
        job.job             = JOB_BYTE;
        job.data            = data_byte;
        job.crc             = crc_cur;
        job.counter         = saved_counter_reg;
        job.rx_pec          = {saved_pec_high_reg, data_byte};
        unique case (mode_cur)
            MODE_CMD:
            begin
                if (pos_cur < POS_W'(COMMAND_BYTES)) begin
                    crc_next = crc15_new;
                    pos_next = pos_inc;
                    has_job  = 1'b1;
                    job.crc  = crc15_new;
                    if (pos_inc == POS_W'(COMMAND_BYTES)) begin
                        job.job         = JOB_CMD_PEC;
                        frame_mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_TX:
            begin
                if (pos_cur < POS_W'(DATA_BYTES)) begin
                    crc_next = {5'b0, crc10_new};
                    pos_next = pos_inc;
                    has_job  = 1'b1;
                    job.crc  = {5'b0, crc10_new};
                    if (pos_inc == POS_W'(DATA_BYTES)) begin
                        job.job         = JOB_TX_PEC;
                        frame_mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_RX:
            begin
                if (pos_cur < POS_W'(DATA_BYTES)) begin
                    crc_next = {5'b0, crc10_new};
                    pos_next = pos_inc;
                    has_job  = 1'b1;
                    job.crc  = {5'b0, crc10_new};
                end else if (pos_cur == POS_W'(DATA_BYTES)) begin
                    // The counter byte is stored and gives no result.
                    saved_counter_next  = data_byte[7:2];
                    saved_pec_high_next = data_byte[1:0];
                    pos_next            = pos_inc;
                end else begin
                    has_job         = 1'b1;
                    job.job         = JOB_STATUS;
                    frame_mode_next = MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
                has_job = 1'b0;
            end
        endcase
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_mode_reg     <= MODE_CMD;
            pos_reg            <= '0;
            crc_reg            <= CRC_SEED;
            saved_counter_reg  <= '0;
            saved_pec_high_reg <= '0;
        end else if (accept) begin
            frame_mode_reg     <= frame_mode_next;
            pos_reg            <= pos_next;
            crc_reg            <= crc_next;
            saved_counter_reg  <= saved_counter_next;
            saved_pec_high_reg <= saved_pec_high_next;
        end
    end

endmodule

/* src/mlpf_queue.sv */
// Short job queue between the front end and the back end.
`include "monitor_link_pec_framer_core_assert.svh"
module mlpf_queue
    import mlpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wr_data,
    input  logic rd,
    output job_t rd_data,
    output logic q_full,
    output logic q_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = entries_reg[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr) begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `MLPF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `MLPF_ASSERT_IMP(a_no_overflow, clk, rst_n, wr && !rd, !q_full, "job written into a full queue")

endmodule

/* src/mlpf_back.sv */
// Back end: expands each job into result beats and holds them in an output register.
`include "monitor_link_pec_framer_core_assert.svh"
module mlpf_back
    import mlpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  job_t        q_head,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic        pec_ok,
    output logic [5:0]  command_counter,
    output logic [9:0]  received_pec,
    output logic [9:0]  computed_pec,
    output logic        last
);

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  sub_reg, sub_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic        ok_reg;
    logic [5:0]  counter_reg;
    logic [9:0]  rx_pec_reg;
    logic [9:0]  cp_reg;
    logic        last_reg;

    logic        load;
    logic        done;
    logic [9:0]  pec10;
    logic [15:0] pec16;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic        r_ok;
    logic [5:0]  r_counter;
    logic [9:0]  r_rx_pec;
    logic [9:0]  r_cp;
    logic        r_last;

    assign load  = (!out_valid_reg || pop) && !q_empty;
    assign q_rd  = load && done;
    assign empty = !out_valid_reg;

    assign kind            = kind_reg;
    assign out_byte        = byte_reg;
    assign pec_ok          = ok_reg;
    assign command_counter = counter_reg;
    assign received_pec    = rx_pec_reg;
    assign computed_pec    = cp_reg;
    assign last            = last_reg;

    // Build the result beat for the current step of the head job.
    always_comb
    begin
        pec10     = pec10_finish(q_head.crc[9:0],
                                 (q_head.job == JOB_STATUS) ? q_head.counter : 6'd0);
        pec16     = (q_head.job == JOB_CMD_PEC) ? {q_head.crc, 1'b0} : {6'b0, pec10};
        r_kind    = KIND_BYTE;
        r_byte    = q_head.data;
        r_ok      = 1'b0;
        r_counter = '0;
        r_rx_pec  = '0;
        r_cp      = '0;
        r_last    = 1'b0;
        done      = 1'b1;
        unique case (q_head.job)
            JOB_BYTE:
            begin
                done = 1'b1;
            end
            JOB_CMD_PEC, JOB_TX_PEC:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        done = 1'b0;
                    end
                    2'd1:
                    begin
                        r_kind = KIND_PEC;
                        r_byte = pec16[15:8];
                        done   = 1'b0;
                    end
                    default:
                    begin
                        r_kind = KIND_PEC;
                        r_byte = pec16[7:0];
                        r_last = 1'b1;
                    end
                endcase
            end
            JOB_STATUS:
            begin
                r_kind    = KIND_STATUS;
                r_byte    = '0;
                r_ok      = (q_head.rx_pec == pec10);
                r_counter = q_head.counter;
                r_rx_pec  = q_head.rx_pec;
                r_cp      = pec10;
                r_last    = 1'b1;
            end
        endcase
        sub_next       = load ? (done ? 2'd0 : sub_reg + 1'b1) : sub_reg;
        out_valid_next = load ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            sub_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg    <= r_kind;
            byte_reg    <= r_byte;
            ok_reg      <= r_ok;
            counter_reg <= r_counter;
            rx_pec_reg  <= r_rx_pec;
            cp_reg      <= r_cp;
            last_reg    <= r_last;
        end
    end

    `MLPF_ASSERT_IMP(a_status_last, clk, rst_n, out_valid_reg && kind_reg == KIND_STATUS, last_reg, "status beat without last")
    `MLPF_ASSERT_IMP(a_mid_job_head, clk, rst_n, sub_reg != 2'd0, !q_empty, "job dequeued before all beats were sent")
    `MLPF_ASSERT_NXT(a_step_advance, clk, rst_n, load && !done, sub_reg != 2'd0, "job step did not advance")

endmodule

/* src/monitor_link_pec_framer_core.sv */
// Top level of the battery monitor link PEC framer.
//
// Input channel: push / full. One beat carries op, data_byte and first; first
// starts a frame of kind op (command with PEC15, transmit data with PEC10, or
// received data check) and reseeds the CRC.
// Result channel: empty / pop. Each beat carries kind, out_byte, the status
// fields and last; the oldest result is shown while empty is low.
// Throughput: one input beat per cycle while full is low. Each beat runs one
// byte-wide CRC step in the front end and queues at most one job; the back end
// emits one result per cycle while pop keeps the output register free, so the
// closing byte of a command or transmit frame gives three result beats (byte
// plus two PEC bytes). An accepted beat's job is written into the queue, and
// its result is then loaded into the output register that drives the ports.
// Reset clears the frame state to a fresh command frame with seed 16 and
// empties the queue and output register.
// When the receiver stalls the output register holds, the queue fills, and
// full rises once QUEUE_DEPTH jobs are waiting.
module monitor_link_pec_framer_core
    import mlpf_pkg::*;
#(
    parameter int COMMAND_BYTES = COMMAND_BYTES_DEF,
    parameter int DATA_BYTES    = DATA_BYTES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] op,
    input  logic [7:0] data_byte,
    input  logic       first,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       pec_ok,
    output logic [5:0] command_counter,
    output logic [9:0] received_pec,
    output logic [9:0] computed_pec,
    output logic       last
);

    logic job_wr;
    job_t job_in;
    job_t job_head;
    logic q_full;
    logic q_empty;
    logic q_rd;

    // Frame tracking and CRC.
    mlpf_front #(
        .COMMAND_BYTES (COMMAND_BYTES),
        .DATA_BYTES    (DATA_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_full    (q_full),
        .op        (op),
        .data_byte (data_byte),
        .first     (first),
        .full      (full),
        .job_wr    (job_wr),
        .job       (job_in)
    );

    // Job queue.
    mlpf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_wr),
        .wr_data (job_in),
        .rd      (q_rd),
        .rd_data (job_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // Result generation.
    mlpf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_head          (job_head),
        .q_rd            (q_rd),
        .pop             (pop),
        .empty           (empty),
        .kind            (kind),
        .out_byte        (out_byte),
        .pec_ok          (pec_ok),
        .command_counter (command_counter),
        .received_pec    (received_pec),
        .computed_pec    (computed_pec),
        .last            (last)
    );

endmodule
